/* sv/navigation_history_deque_core_macros.svh */
// Assertion macros used by the navigation history deque core.
`ifndef NAVIGATION_HISTORY_DEQUE_CORE_MACROS_SVH
`define NAVIGATION_HISTORY_DEQUE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Property that holds at every clock edge outside reset.
`define NHD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("navigation history deque assertion failed");

// Condition that forces another condition at the next clock edge.
`define NHD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("navigation history deque sequence check failed");

`else

`define NHD_ASSERT(lbl, prop)
`define NHD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* sv/nhd_pkg.sv */
// Types, constants and codes of the navigation history deque.
`default_nettype none

package nhd_pkg;

    // Chain geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths
    localparam int MODE_W     = 3;
    localparam int TYPE_W     = 4;
    localparam int COORD_W    = 16;
    localparam int MASK_W     = 16;
    localparam int MASK_IDX_W = $clog2(MASK_W);
    localparam int RIDX_W     = 4;
    localparam int ECNT_W     = 5;
    localparam int LIMIT_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Command modes
    localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ROTATE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_MASK   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHART_CODE = 1'd1;

    // One stored entry
    typedef struct packed {
        logic [TYPE_W-1:0]         kind;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } entry_t;

    // Command word
    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [TYPE_W-1:0]         entry_type;
        logic signed [COORD_W-1:0] entry_x;
        logic signed [COORD_W-1:0] entry_y;
        logic [MASK_W-1:0]         keep_mask;
        logic [RIDX_W-1:0]         read_index;
    } cmd_t;

    // Result word
    typedef struct packed {
        logic                      result_valid;
        logic [TYPE_W-1:0]         result_type;
        logic signed [COORD_W-1:0] result_x;
        logic signed [COORD_W-1:0] result_y;
        logic [ECNT_W-1:0]         entry_count;
    } rsp_t;

    // Move applied to the whole chain at once
    typedef enum logic [2:0] {
        CH_HOLD,
        CH_LOAD_HEAD,
        CH_SHIFT_UP,
        CH_REMOVE,
        CH_ROTATE
    } chain_op_t;

    typedef struct packed {
        chain_op_t        op;
        logic [IDX_W-1:0] bound;
    } chain_ctl_t;

endpackage

`default_nettype wire

/* sv/nhd_slot.sv */
// One entry slot of the chain; slot 0 holds the newest entry.
`default_nettype none

module nhd_slot
    import nhd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic [IDX_W-1:0] slot_idx,
    input  wire chain_ctl_t       ctl,
    input  wire entry_t           from_lo,
    input  wire entry_t           from_hi,
    input  wire entry_t           head,
    output entry_t                data
);

    entry_t data_reg;
    entry_t data_next;

    // Pick the new value from this slot, a neighbor or the head
    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            CH_LOAD_HEAD:
            begin
                if (slot_idx == '0)
                begin
                    data_next = from_lo;
                end
            end
            CH_SHIFT_UP:
            begin
                data_next = from_lo;
            end
            CH_REMOVE:
            begin
                if (slot_idx >= ctl.bound)
                begin
                    data_next = from_hi;
                end
            end
            CH_ROTATE:
            begin
                if (slot_idx < ctl.bound)
                begin
                    data_next = from_hi;
                end
                else if (slot_idx == ctl.bound)
                begin
                    data_next = head;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* sv/navigation_history_deque_core.sv */
// Top level of the navigation history deque: command sequencer and slot chain.
//
//  channel   | signals                              | handshake
//  ----------+--------------------------------------+------------------------------
//  command   | start, busy, cmd                     | taken when start && !busy
//  result    | done, rsp                            | one-cycle strobe, no stall
//  config    | cfg_valid, cfg_ready, cfg_index/data | taken when valid && ready
//
// A command word is accepted, the chain tap is read on the next edge, and the
// result strobes from the execute state that follows for push, pop, rotate,
// clear and read. Mask walks the live entries one per cycle, then strobes.
// busy drops in the strobe cycle, so a new word may follow at once.
// Reset empties the list and loads size limit 16, chart type 1; slot contents
// stay unknown and are never used before written. The result side never stalls.
`include "navigation_history_deque_core_macros.svh"
`default_nettype none

module navigation_history_deque_core
    import nhd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire cmd_t                  cmd,
    output logic                       done,
    output rsp_t                       rsp,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EXEC,
        S_MASK
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    entry_t              tap_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic                done_reg, done_next;
    rsp_t                rsp_reg, rsp_next;
    logic [LIMIT_W-1:0]  size_limit_reg;
    logic [TYPE_W-1:0]   chart_code_reg;

    chain_ctl_t          ctl;
    entry_t              slot_q [DEPTH];
    entry_t              push_e;
    logic [CNT_W-1:0]    lim;
    logic [IDX_W-1:0]    look_addr;
    logic                read_hit;
    logic                keep_bit;
    logic                rsp_blank;

    function automatic logic alike(entry_t a, entry_t b, logic [TYPE_W-1:0] chart);
        return (a == b) || ((a.kind == chart) && (b.kind == chart));
    endfunction

    assign push_e = '{kind: cmd_reg.entry_type, x: cmd_reg.entry_x, y: cmd_reg.entry_y};

    // Slot chain, newest at slot 0
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_chain
        entry_t lo_w;
        entry_t hi_w;
        if (g == 0)
        begin : g_first
            assign lo_w = push_e;
        end
        else
        begin : g_lower
            assign lo_w = slot_q[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_last
            assign hi_w = slot_q[g];
        end
        else
        begin : g_upper
            assign hi_w = slot_q[g+1];
        end
        nhd_slot u_slot (
            .clk      (clk),
            .slot_idx (IDX_W'(g)),
            .ctl      (ctl),
            .from_lo  (lo_w),
            .from_hi  (hi_w),
            .head     (slot_q[0]),
            .data     (slot_q[g])
        );
    end

    // Effective size limit, clamped to 1..DEPTH
    always_comb
    begin
        if (size_limit_reg == '0)
        begin
            lim = CNT_W'(1);
        end
        else if (32'(size_limit_reg) > DEPTH)
        begin
            lim = CNT_W'(DEPTH);
        end
        else
        begin
            lim = CNT_W'(size_limit_reg);
        end
    end

    // Tap address: oldest entry, or the read position counted from the oldest
    always_comb
    begin
        if (cmd_reg.mode == MODE_READ)
        begin
            look_addr = IDX_W'(count_reg - CNT_W'(1) - CNT_W'(cmd_reg.read_index));
        end
        else
        begin
            look_addr = IDX_W'(count_reg - CNT_W'(1));
        end
    end

    assign read_hit = 32'(cmd_reg.read_index) < 32'(count_reg);
    assign keep_bit = (32'(pos_reg) < MASK_W) && cmd_reg.keep_mask[MASK_IDX_W'(pos_reg)];

    // Sequencer next state and chain control
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cur_next   = cur_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        ctl        = '{op: CH_HOLD, bound: '0};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (cmd_reg.mode == MODE_MASK)
                begin
                    state_next = S_MASK;
                    cur_next   = IDX_W'(count_reg - CNT_W'(1));
                    pos_next   = '0;
                    rem_next   = count_reg;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                rsp_next   = '0;
                case (cmd_reg.mode) inside
                    MODE_PUSH:
                    begin
                        if ((count_reg != '0) && alike(push_e, slot_q[0], chart_code_reg))
                        begin
                            ctl.op = CH_LOAD_HEAD;
                        end
                        else if ((count_reg != '0) && alike(push_e, tap_reg, chart_code_reg))
                        begin
                            ctl.op = CH_SHIFT_UP;
                        end
                        else if ((count_reg > CNT_W'(2)) && (slot_q[1] == push_e)
                                 && (slot_q[0] == slot_q[2]))
                        begin
                            ctl.op     = CH_REMOVE;
                            count_next = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            ctl.op = CH_SHIFT_UP;
                            if (count_reg < lim)
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                    end
                    MODE_POP, MODE_ROTATE:
                    begin
                        if (count_reg != '0)
                        begin
                            ctl.op    = CH_ROTATE;
                            ctl.bound = IDX_W'(count_reg - CNT_W'(1));
                            if (cmd_reg.mode == MODE_POP)
                            begin
                                rsp_next.result_valid = 1'b1;
                                rsp_next.result_type  = slot_q[0].kind;
                                rsp_next.result_x     = slot_q[0].x;
                                rsp_next.result_y     = slot_q[0].y;
                            end
                        end
                    end
                    MODE_CLEAR:
                    begin
                        count_next = '0;
                    end
                    MODE_READ:
                    begin
                        if (read_hit)
                        begin
                            rsp_next.result_valid = 1'b1;
                            rsp_next.result_type  = tap_reg.kind;
                            rsp_next.result_x     = tap_reg.x;
                            rsp_next.result_y     = tap_reg.y;
                        end
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
                rsp_next.entry_count = ECNT_W'(count_next);
            end
            S_MASK:
            begin
                if (rem_reg == '0)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    rsp_next   = '0;
                    rsp_next.entry_count = ECNT_W'(count_reg);
                end
                else
                begin
                    // walk from the oldest slot toward the newest
                    if (!keep_bit)
                    begin
                        ctl.op     = CH_REMOVE;
                        ctl.bound  = cur_reg;
                        count_next = count_reg - CNT_W'(1);
                    end
                    cur_next = cur_reg - IDX_W'(1);
                    pos_next = pos_reg + CNT_W'(1);
                    rem_next = rem_reg - CNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, counters, registered outputs and config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            cur_reg        <= '0;
            pos_reg        <= '0;
            rem_reg        <= '0;
            done_reg       <= 1'b0;
            rsp_reg        <= '0;
            size_limit_reg <= LIMIT_W'(16);
            chart_code_reg <= TYPE_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cur_reg   <= cur_next;
            pos_reg   <= pos_next;
            rem_reg   <= rem_next;
            done_reg  <= done_next;
            rsp_reg   <= rsp_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_SIZE_LIMIT: size_limit_reg <= LIMIT_W'(cfg_data);
                    CFG_CHART_CODE: chart_code_reg <= TYPE_W'(cfg_data);
                    default:        chart_code_reg <= chart_code_reg;
                endcase
            end
        end
    end

    // Command word and tap read
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            cmd_reg <= cmd;
        end
        if (state_reg == S_LOOK)
        begin
            tap_reg <= slot_q[look_addr];
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    // Entry fields of the result word all zero
    assign rsp_blank = (rsp_reg.result_type == '0) && (rsp_reg.result_x == '0)
                       && (rsp_reg.result_y == '0);

    // Checks
    `NHD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `NHD_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg)
    `NHD_ASSERT(a_count_range, count_reg <= CNT_W'(DEPTH))
    `NHD_ASSERT(a_empty_fields, !done_reg || rsp_reg.result_valid || rsp_blank)

endmodule

`default_nettype wire
